@@ sv/device_presence_table_unit_macros.svh @@
// Assertion macros for the checker file of the device presence table.
// No dependencies.
`ifndef DEVICE_PRESENCE_TABLE_UNIT_MACROS_SVH
`define DEVICE_PRESENCE_TABLE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DPT_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define DPT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

@@ sv/dpt_pkg.sv @@
// Package of the device presence table: sizes, request and status codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dpt_pkg;
	localparam int Buckets  = 16;
	localparam int Capacity = 64;
	localparam int SW = $clog2(Capacity);
	localparam int BW = (Buckets > 1) ? $clog2(Buckets) : 1;
	localparam logic [6:0] NONE_SLOT = 7'd127;
	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	localparam logic [2:0] REQ_INS_SELF = 3'd0;
	localparam logic [2:0] REQ_INSERT   = 3'd1;
	localparam logic [2:0] REQ_LOOKUP   = 3'd2;
	localparam logic [2:0] REQ_DELETE   = 3'd3;
	localparam logic [2:0] REQ_LIST     = 3'd4;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_LIST      = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] entry_ip;
		logic [47:0] entry_mac;
		logic        entry_is_new;
		logic        entry_is_self;
		logic [15:0] absence_count;
		logic        last_item;
	} rsp_t;

	// One stored entry, kept in one RAM word.
	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic        is_new;
		logic        is_self;
		logic [15:0] absence;
		logic [6:0]  next;
	} slot_t;

	localparam int SlotW = $bits(slot_t);
endpackage
`default_nettype wire

@@ sv/dpt_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dpt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ sv/dpt_bucket.sv @@
// Bucket index: first three MAC bytes modulo the bucket count, registered.
// Depends on dpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dpt_bucket import dpt_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [47:0]   mac,
	output logic               done,
	output logic [BW-1:0]      bucket
);
	// Key is b0 | b1<<8 | b2<<16; the bucket count is a power of two, so the
	// residue is the low key bits. Ready in the cycle after start.
	logic [23:0]   key;
	logic [BW-1:0] bucket_q;

	assign key = {mac[31:24], mac[39:32], mac[47:40]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bucket_q <= BW'(key % 24'(Buckets));
		end
	end

	assign bucket = bucket_q;
endmodule
`default_nettype wire

@@ sv/dpt_ctrl.sv @@
// Sequencer of the device presence table: chain walks, slot search, list pass.
// Depends on dpt_pkg, dpt_ram, dpt_bucket.
`timescale 1ns / 1ps
`default_nettype none
module dpt_ctrl import dpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_item,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_item
);
	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_HASH   = 12'b000000000010,
		S_WALK   = 12'b000000000100,
		S_WCHK   = 12'b000000001000,
		S_FREE   = 12'b000000010000,
		S_WRITE  = 12'b000000100000,
		S_UNLINK = 12'b000001000000,
		S_PREVRD = 12'b000010000000,
		S_LHEAD  = 12'b000100000000,
		S_LRD    = 12'b001000000000,
		S_LCHK   = 12'b010000000000,
		S_OUT    = 12'b100000000000
	} state_t;

	state_t         state_q;
	req_t           req_q;
	logic [Capacity-1:0] valid_q;
	logic [6:0]     head_q [Buckets];
	logic [SW:0]    count_q;
	logic [BW-1:0]  bkt_q;
	logic [6:0]     cur_q;
	logic [6:0]     prev_q;
	logic [SW:0]    steps_q;
	logic [SW:0]    free_q;
	logic           any_q;
	logic           lastb_q;
	rsp_t           rsp_q;
	rsp_t           pend_q;
	logic           out_v_q;

	// Single shared slot store.
	logic           ram_we;
	logic [SW-1:0]  ram_addr;
	slot_t          ram_wdata;
	logic [SlotW-1:0] ram_rdata;
	slot_t          rd;

	logic           hash_done;
	logic [BW-1:0]  hash_bkt;

	dpt_ram #(.Width(SlotW), .Depth(Capacity)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	dpt_bucket u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && in_ready),
		.mac    (in_item.mac_addr),
		.done   (hash_done),
		.bucket (hash_bkt)
	);

	assign rd = slot_t'(ram_rdata);
	assign in_ready  = (state_q == S_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_item  = rsp_q;

	function automatic logic live(input logic [6:0] s, input logic [Capacity-1:0] v);
		live = (s < 7'(Capacity)) && v[s[SW-1:0]];
	endfunction

	function automatic rsp_t mk(input logic [2:0] st, input slot_t e, input logic hit,
			input logic last);
		rsp_t r;
		r = '0;
		r.status = st;
		if (hit) begin
			r.entry_ip = e.ip;
			r.entry_mac = e.mac;
			r.entry_is_new = e.is_new;
			r.entry_is_self = e.is_self;
			r.absence_count = e.absence;
		end
		r.last_item = last;
		mk = r;
	endfunction

	logic is_self_req;
	assign is_self_req = (req_q.req_type == REQ_INS_SELF);

	// RAM port control.
	always_comb begin
		ram_we = 1'b0;
		ram_addr = cur_q[SW-1:0];
		ram_wdata = rd;
		unique case (state_q)
			S_WRITE: begin
				ram_we = 1'b1;
				ram_addr = free_q[SW-1:0];
				ram_wdata.ip = req_q.ip_addr;
				ram_wdata.mac = req_q.mac_addr;
				ram_wdata.is_new = 1'b1;
				ram_wdata.is_self = is_self_req;
				ram_wdata.absence = '0;
				ram_wdata.next = head_q[bkt_q];
			end
			S_WCHK: begin
				// duplicate insert refreshes the entry in place
				if (live(cur_q, valid_q) && rd.ip == req_q.ip_addr
						&& req_q.req_type == REQ_INSERT && !out_v_q) begin
					ram_we = 1'b1;
					ram_wdata.absence = '0;
					ram_wdata.is_self = 1'b0;
				end
			end
			S_UNLINK: begin
				// fetch the predecessor
				ram_addr = prev_q[SW-1:0];
			end
			S_PREVRD: begin
				ram_we = 1'b1;
				ram_addr = prev_q[SW-1:0];
				ram_wdata.next = cur_q;
			end
			S_LCHK: begin
				ram_we = !out_v_q;
				ram_wdata.is_new = 1'b0;
				if (!rd.is_self && rd.absence != AGE_MAX) begin
					ram_wdata.absence = rd.absence + 16'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			count_q <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < Buckets; i++) head_q[i] <= NONE_SLOT;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						if (in_item.req_type == REQ_LIST) begin
							bkt_q   <= '0;
							any_q   <= 1'b0;
							steps_q <= '0;
							state_q <= S_LHEAD;
						end else if (in_item.req_type <= REQ_DELETE) begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						bkt_q   <= hash_bkt;
						cur_q   <= head_q[hash_bkt];
						prev_q  <= NONE_SLOT;
						steps_q <= '0;
						free_q  <= '0;
						state_q <= is_self_req ? S_FREE : S_WALK;
					end
				end
				S_WALK: begin
					// read issued for cur_q this cycle
					if (live(cur_q, valid_q) && steps_q < (SW+1)'(Capacity)) state_q <= S_WCHK;
					else if (req_q.req_type == REQ_INSERT) state_q <= S_FREE;
					else begin
						rsp_q   <= mk(ST_NOT_FOUND, rd, 1'b0, 1'b1);
						state_q <= S_OUT;
					end
				end
				S_WCHK: begin
					if (rd.ip == req_q.ip_addr) begin
						unique case (req_q.req_type)
							REQ_INSERT: begin
								rsp_q <= mk(ST_PRESENT, rd, 1'b1, 1'b1);
								state_q <= S_OUT;
							end
							REQ_DELETE: begin
								rsp_q <= mk(ST_DONE, rd, 1'b1, 1'b1);
								valid_q[cur_q[SW-1:0]] <= 1'b0;
								if (count_q != '0) count_q <= count_q - (SW+1)'(1);
								if (live(prev_q, valid_q)) begin
									cur_q   <= rd.next;
									state_q <= S_UNLINK;
								end else begin
									head_q[bkt_q] <= rd.next;
									state_q <= S_OUT;
								end
							end
							default: begin
								rsp_q <= mk(ST_DONE, rd, 1'b1, 1'b1);
								state_q <= S_OUT;
							end
						endcase
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rd.next;
						steps_q <= steps_q + (SW+1)'(1);
						state_q <= S_WALK;
					end
				end
				S_UNLINK: begin
					// read the predecessor, then rewrite its link
					state_q <= S_PREVRD;
				end
				S_PREVRD: begin
					state_q <= S_OUT;
				end
				S_FREE: begin
					// one slot checked per cycle, lowest first
					if (count_q >= (SW+1)'(Capacity) || free_q >= (SW+1)'(Capacity)) begin
						rsp_q <= mk(ST_FULL, rd, 1'b0, 1'b1);
						state_q <= S_OUT;
					end else if (!valid_q[free_q[SW-1:0]]) begin
						state_q <= S_WRITE;
					end else begin
						free_q <= free_q + (SW+1)'(1);
					end
				end
				S_WRITE: begin
					valid_q[free_q[SW-1:0]] <= 1'b1;
					head_q[bkt_q] <= 7'(free_q);
					count_q <= count_q + (SW+1)'(1);
					rsp_q <= mk(ST_DONE, ram_wdata, 1'b1, 1'b1);
					state_q <= S_OUT;
				end
				S_LHEAD: begin
					cur_q   <= head_q[bkt_q];
					lastb_q <= (bkt_q == BW'(Buckets - 1));
					state_q <= S_LRD;
				end
				S_LRD: begin
					if (live(cur_q, valid_q) && steps_q < (SW+1)'(Capacity)) state_q <= S_LCHK;
					else if (!lastb_q) begin
						bkt_q   <= bkt_q + BW'(1);
						state_q <= S_LHEAD;
					end else begin
						if (out_v_q) state_q <= S_LRD;
						else begin
							rsp_q <= any_q ? {pend_q[$bits(rsp_t)-1:1], 1'b1}
								: mk(ST_EMPTY, rd, 1'b0, 1'b1);
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_LCHK: begin
					// emit the pending entry, hold the new one until the next is known
					if (!out_v_q) begin
						if (any_q) begin
							rsp_q   <= pend_q;
							out_v_q <= 1'b1;
						end
						pend_q  <= mk(ST_LIST, rd, 1'b1, 1'b0);
						any_q   <= 1'b1;
						steps_q <= steps_q + (SW+1)'(1);
						cur_q   <= rd.next;
						state_q <= S_LRD;
					end
				end
				S_OUT: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the request.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_item;
	end
endmodule
`default_nettype wire

@@ sv/device_presence_table_unit.sv @@
// Device presence table: chained hash of device entries keyed by IPv4 within a MAC bucket.
// Usage: requests enter on in_valid/in_ready as req_t items (insert self, insert,
// lookup, delete, list). Results leave on out_valid/out_ready as rsp_t items.
// One request is handled at a time; in_ready is low from acceptance until its
// last result is taken, and rises the cycle after that.
// Sequence: the bucket index (low bits of the MAC key) is registered first; then
// each chain entry visited is read from the single-port slot RAM (S_WALK) and
// compared (S_WCHK), and the result goes out from S_OUT. An insert self skips
// the walk. A delete behind the head reads and relinks its predecessor
// (S_UNLINK, S_PREVRD); an insert searches for the lowest free slot (S_FREE)
// and writes it (S_WRITE). A list request visits each bucket head (S_LHEAD)
// and each entry (S_LRD, S_LCHK), and emits one item per entry.
// Every non-list request of a defined type gives one result with last_item set; a list gives one
// item per entry, the final one marked, or a single empty item.
// Reset clears all valid bits, bucket heads and the entry count at once;
// no clearing pass is needed. When the receiver stalls, a list pass runs on to
// its next item and the sequencer then holds until the pending item is taken.
// Depends on dpt_pkg, dpt_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module device_presence_table_unit import dpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_data
);
	dpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_data)
	);
endmodule
`default_nettype wire

@@ sv/dpt_checker.sv @@
// Port-level checker of the device presence table, bound to the top level.
// Depends on dpt_pkg and device_presence_table_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "device_presence_table_unit_macros.svh"
module dpt_checker import dpt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire req_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsp_t out_data
);
	// A result stays until taken.
	`DPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// No new item accepted while a result is shown.
	`DPT_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// Status codes stay in range.
	`DPT_ASSERT_IMP(a_status, clk, arst_n, out_valid, out_data.status <= ST_EMPTY)
	// Non-list status always marks the last item.
	`DPT_ASSERT_IMP(a_last, clk, arst_n, out_valid && out_data.status != ST_LIST, out_data.last_item)
endmodule

bind device_presence_table_unit dpt_checker u_dpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
